[rtl/core/avru_pkg.sv]
// Shared types and constants for the vector rotation unit.
// Used by avru_angle, avru_cordic, avru_rotate and axis_vector_rotation_unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package avru_pkg;

  localparam int COORD_W       = 32;
  localparam int ANGLE_W       = 32;
  localparam int TRIG_W        = 32;
  localparam int CORDIC_STAGES = 16;
  localparam int TRIG_FRAC     = 30;

  // angle folded into [-90, 90] degrees, Q8.16
  localparam int FOLD_W = 24;
  // unsigned angle in [0, 360) degrees, Q9.16
  localparam int DEG_W  = 25;

  localparam logic [DEG_W-1:0] DEG_QUARTER = DEG_W'(90 * 65536);
  localparam logic [DEG_W-1:0] DEG_HALF    = DEG_W'(180 * 65536);
  localparam logic [DEG_W-1:0] DEG_THREE_Q = DEG_W'(270 * 65536);
  localparam logic [DEG_W-1:0] DEG_FULL    = DEG_W'(360 * 65536);

  // integer degrees biased positive: 92 * 360, then mod 360 as 8 * (v mod 45)
  localparam int HI_BIAS   = 92 * 360;
  localparam int MOD_BASE  = 45;
  localparam int MOD_SHIFT = 16;
  localparam int MOD_RECIP = (1 << MOD_SHIFT) / MOD_BASE;

  // pi/180 in Q.44, split for two narrow multipliers
  localparam logic [63:0] DEG2RAD_Q44 = 64'd307041569098;
  localparam int          RAD_SPLIT   = 20;
  localparam logic signed [20:0] RAD_C_HI = 21'(DEG2RAD_Q44 >> RAD_SPLIT);
  localparam logic signed [20:0] RAD_C_LO =
    21'(DEG2RAD_Q44 & ((64'd1 << RAD_SPLIT) - 64'd1));

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = TRIG_W'(652032874);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_BAD = 2'd3
  } axis_t;

  // operands that ride alongside the angle path
  typedef struct packed {
    axis_t                     axis;
    logic                      neg;
    logic signed [COORD_W-1:0] pass;
    logic signed [COORD_W-1:0] p;
    logic signed [COORD_W-1:0] q;
  } side_t;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic signed [TRIG_W-1:0] atan_q30(input int idx);
    logic signed [TRIG_W-1:0] v;
    case (idx)
      0:  v = TRIG_W'(843314857);
      1:  v = TRIG_W'(497837829);
      2:  v = TRIG_W'(263043837);
      3:  v = TRIG_W'(133525159);
      4:  v = TRIG_W'(67021687);
      5:  v = TRIG_W'(33543516);
      6:  v = TRIG_W'(16775851);
      7:  v = TRIG_W'(8388437);
      8:  v = TRIG_W'(4194283);
      9:  v = TRIG_W'(2097149);
      10: v = TRIG_W'(1048576);
      11: v = TRIG_W'(524288);
      12: v = TRIG_W'(262144);
      13: v = TRIG_W'(131072);
      14: v = TRIG_W'(65536);
      15: v = TRIG_W'(32768);
      16: v = TRIG_W'(16384);
      17: v = TRIG_W'(8192);
      18: v = TRIG_W'(4096);
      19: v = TRIG_W'(2048);
      20: v = TRIG_W'(1024);
      21: v = TRIG_W'(512);
      22: v = TRIG_W'(256);
      23: v = TRIG_W'(128);
      24: v = TRIG_W'(64);
      25: v = TRIG_W'(32);
      26: v = TRIG_W'(16);
      27: v = TRIG_W'(8);
      28: v = TRIG_W'(4);
      29: v = TRIG_W'(2);
      30: v = TRIG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/avru_angle.sv]
// Angle front end: reduce degrees mod 360, fold to [-90, 90], convert to Q30 radians.
// Five register stages with per-stage valid and ready. Depends on avru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avru_angle (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   valid_i,
  output logic                                        ready_o,
  input  wire logic signed [avru_pkg::ANGLE_W-1:0]    angle_i,
  input  wire avru_pkg::side_t                        side_i,
  output logic                                        valid_o,
  input  wire logic                                   ready_i,
  output logic signed [avru_pkg::TRIG_W-1:0]          theta_o,
  output avru_pkg::side_t                             side_o
);

  localparam int NSTG = 5;
  localparam int ANGLE_HI_MSB = avru_pkg::ANGLE_W - 1;

  logic vld_r [NSTG];
  logic en    [NSTG];

  // stage A: bias integer degrees, estimate quotient by 45
  logic [16:0]           hb_nxt;
  logic [13:0]           vm_nxt;
  logic [24:0]           qm_nxt;
  logic [24:0]           qm_r;
  logic [13:0]           vm_r;
  logic [2:0]            l3_r;
  logic [15:0]           lo_r;
  avru_pkg::side_t       sa_r;

  // stage B: remainder, rebuild angle in [0, 360)
  logic [8:0]            q_est;
  logic [13:0]           q45;
  logic [13:0]           rem_raw;
  logic [5:0]            rem;
  logic [avru_pkg::DEG_W-1:0] a_nxt;
  logic [avru_pkg::DEG_W-1:0] a_r;
  avru_pkg::side_t       sb_r;

  // stage C: fold to [-90, 90]
  logic signed [avru_pkg::DEG_W:0]      a_s;
  logic signed [avru_pkg::DEG_W:0]      af_full;
  logic signed [avru_pkg::FOLD_W-1:0]   af_r;
  avru_pkg::side_t                      sc_nxt;
  avru_pkg::side_t                      sc_r;

  // stage D: split multiply by pi/180
  logic signed [44:0]    ph_r;
  logic signed [44:0]    pl_r;
  avru_pkg::side_t       sd_r;

  // stage E: combine and round to Q30
  logic signed [63:0]    tsum;
  logic signed [avru_pkg::TRIG_W-1:0] theta_r;
  avru_pkg::side_t       se_r;

  assign en[NSTG-1] = !vld_r[NSTG-1] || ready_i;
  assign en[3]      = !vld_r[3] || en[4];
  assign en[2]      = !vld_r[2] || en[3];
  assign en[1]      = !vld_r[1] || en[2];
  assign en[0]      = !vld_r[0] || en[1];

  assign ready_o = en[0];
  assign valid_o = vld_r[NSTG-1];
  assign theta_o = theta_r;
  assign side_o  = se_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      if (en[0]) vld_r[0] <= valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_comb begin
    hb_nxt = 17'({angle_i[ANGLE_HI_MSB], angle_i[ANGLE_HI_MSB:16]} + 17'(avru_pkg::HI_BIAS));
    vm_nxt = hb_nxt[16:3];
    qm_nxt = 25'(vm_nxt) * 25'(avru_pkg::MOD_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      qm_r <= qm_nxt;
      vm_r <= vm_nxt;
      l3_r <= hb_nxt[2:0];
      lo_r <= angle_i[15:0];
      sa_r <= side_i;
    end
  end

  always_comb begin
    q_est   = qm_r[24:avru_pkg::MOD_SHIFT];
    q45     = 14'(q_est * 14'(avru_pkg::MOD_BASE));
    rem_raw = vm_r - q45;
    if (rem_raw >= 14'(avru_pkg::MOD_BASE)) begin
      rem = 6'(rem_raw - 14'(avru_pkg::MOD_BASE));
    end else begin
      rem = 6'(rem_raw);
    end
    a_nxt = {rem, l3_r, lo_r};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a_r  <= a_nxt;
      sb_r <= sa_r;
    end
  end

  always_comb begin
    a_s    = $signed({1'b0, a_r});
    sc_nxt = sb_r;
    if (a_r <= avru_pkg::DEG_QUARTER) begin
      af_full    = a_s;
      sc_nxt.neg = 1'b0;
    end else if (a_r < avru_pkg::DEG_THREE_Q) begin
      af_full    = a_s - $signed({1'b0, avru_pkg::DEG_HALF});
      sc_nxt.neg = 1'b1;
    end else begin
      af_full    = a_s - $signed({1'b0, avru_pkg::DEG_FULL});
      sc_nxt.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      af_r <= af_full[avru_pkg::FOLD_W-1:0];
      sc_r <= sc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ph_r <= 45'(af_r) * 45'(avru_pkg::RAD_C_HI);
      pl_r <= 45'(af_r) * 45'(avru_pkg::RAD_C_LO);
      sd_r <= sc_r;
    end
  end

  always_comb begin
    tsum = (64'(ph_r) <<< avru_pkg::RAD_SPLIT) + 64'(pl_r)
         + (64'sd1 <<< (avru_pkg::TRIG_FRAC - 1));
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      theta_r <= tsum[avru_pkg::TRIG_FRAC +: avru_pkg::TRIG_W];
      se_r    <= sd_r;
    end
  end

endmodule

`default_nettype wire

[rtl/core/avru_cordic.sv]
// Rotation-mode CORDIC, one micro-rotation per register stage.
// Produces cosine and sine in Q30 from a Q30 angle. Depends on avru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avru_cordic (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 valid_i,
  output logic                                      ready_o,
  input  wire logic signed [avru_pkg::TRIG_W-1:0]   theta_i,
  input  wire avru_pkg::side_t                      side_i,
  output logic                                      valid_o,
  input  wire logic                                 ready_i,
  output logic signed [avru_pkg::TRIG_W-1:0]        cos_o,
  output logic signed [avru_pkg::TRIG_W-1:0]        sin_o,
  output avru_pkg::side_t                           side_o
);

  localparam int NSTG = avru_pkg::CORDIC_STAGES;

  logic                             vld_r  [NSTG];
  logic                             en     [NSTG];
  logic signed [avru_pkg::TRIG_W-1:0] x_r  [NSTG];
  logic signed [avru_pkg::TRIG_W-1:0] y_r  [NSTG];
  logic signed [avru_pkg::TRIG_W-1:0] z_r  [NSTG];
  avru_pkg::side_t                  sd_r   [NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    logic                               vi;
    logic signed [avru_pkg::TRIG_W-1:0] xi;
    logic signed [avru_pkg::TRIG_W-1:0] yi;
    logic signed [avru_pkg::TRIG_W-1:0] zi;
    avru_pkg::side_t                    si;
    logic signed [avru_pkg::TRIG_W-1:0] x_nxt;
    logic signed [avru_pkg::TRIG_W-1:0] y_nxt;
    logic signed [avru_pkg::TRIG_W-1:0] z_nxt;

    if (i == 0) begin : g_head
      assign vi = valid_i;
      assign xi = avru_pkg::CORDIC_GAIN_Q30;
      assign yi = '0;
      assign zi = theta_i;
      assign si = side_i;
    end else begin : g_link
      assign vi = vld_r[i-1];
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign si = sd_r[i-1];
    end

    if (i == NSTG - 1) begin : g_tail
      assign en[i] = !vld_r[i] || ready_i;
    end else begin : g_mid
      assign en[i] = !vld_r[i] || en[i+1];
    end

    always_comb begin
      if (!zi[avru_pkg::TRIG_W-1]) begin
        x_nxt = xi - (yi >>> i);
        y_nxt = yi + (xi >>> i);
        z_nxt = zi - avru_pkg::atan_q30(i);
      end else begin
        x_nxt = xi + (yi >>> i);
        y_nxt = yi - (xi >>> i);
        z_nxt = zi + avru_pkg::atan_q30(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en[i]) begin
        vld_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        x_r[i]  <= x_nxt;
        y_r[i]  <= y_nxt;
        z_r[i]  <= z_nxt;
        sd_r[i] <= si;
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_r[NSTG-1];
  assign cos_o   = x_r[NSTG-1];
  assign sin_o   = y_r[NSTG-1];
  assign side_o  = sd_r[NSTG-1];

endmodule

`default_nettype wire

[rtl/core/avru_rotate.sv]
// Rotation back end: products, sums, rounding, saturation and the output register.
// Four register stages with per-stage valid and ready. Depends on avru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avru_rotate (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 valid_i,
  output logic                                      ready_o,
  input  wire logic signed [avru_pkg::TRIG_W-1:0]   cos_i,
  input  wire logic signed [avru_pkg::TRIG_W-1:0]   sin_i,
  input  wire avru_pkg::side_t                      side_i,
  output logic                                      valid_o,
  input  wire logic                                 ready_i,
  output logic signed [avru_pkg::COORD_W-1:0]       x_o,
  output logic signed [avru_pkg::COORD_W-1:0]       y_o,
  output logic signed [avru_pkg::COORD_W-1:0]       z_o,
  output logic                                      bad_o
);

  localparam int NSTG  = 4;
  localparam int PW    = avru_pkg::COORD_W + avru_pkg::TRIG_W;
  localparam int SW    = PW + 1;
  localparam int RW    = PW + 2;
  localparam int OW    = RW - avru_pkg::TRIG_FRAC;

  localparam logic signed [RW-1:0] RND = RW'(1) <<< (avru_pkg::TRIG_FRAC - 1);

  logic vld_r [NSTG];
  logic en    [NSTG];

  logic signed [PW-1:0] pc_r, qs_r, ps_r, qc_r;
  avru_pkg::side_t      sm_r;

  logic signed [SW-1:0] sa_r, sb_r;
  avru_pkg::side_t      ss_r;

  logic signed [RW-1:0] ra_full, rb_full;
  logic signed [OW-1:0] ra_r, rb_r;
  avru_pkg::side_t      sn_r;

  logic signed [avru_pkg::COORD_W-1:0] a_sat, b_sat;
  logic signed [avru_pkg::COORD_W-1:0] x_nxt, y_nxt, z_nxt;
  logic                                bad_nxt;
  logic signed [avru_pkg::COORD_W-1:0] x_r, y_r, z_r;
  logic                                bad_r;

  function automatic logic signed [avru_pkg::COORD_W-1:0] sat_coord(
    input logic signed [OW-1:0] v
  );
    logic signed [avru_pkg::COORD_W-1:0] r;
    if (v > OW'(avru_pkg::COORD_MAX)) begin
      r = avru_pkg::COORD_MAX;
    end else if (v < OW'(avru_pkg::COORD_MIN)) begin
      r = avru_pkg::COORD_MIN;
    end else begin
      r = v[avru_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  assign en[NSTG-1] = !vld_r[NSTG-1] || ready_i;
  assign en[2]      = !vld_r[2] || en[3];
  assign en[1]      = !vld_r[1] || en[2];
  assign en[0]      = !vld_r[0] || en[1];

  assign ready_o = en[0];
  assign valid_o = vld_r[NSTG-1];
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign bad_o   = bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      if (en[0]) vld_r[0] <= valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pc_r <= side_i.p * cos_i;
      qs_r <= side_i.q * sin_i;
      ps_r <= side_i.p * sin_i;
      qc_r <= side_i.q * cos_i;
      sm_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sa_r <= SW'(pc_r) - SW'(qs_r);
      sb_r <= SW'(ps_r) + SW'(qc_r);
      ss_r <= sm_r;
    end
  end

  // negate the whole sum when the angle was folded by 180 degrees
  always_comb begin
    if (ss_r.neg) begin
      ra_full = RND - RW'(sa_r);
      rb_full = RND - RW'(sb_r);
    end else begin
      ra_full = RW'(sa_r) + RND;
      rb_full = RW'(sb_r) + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ra_r <= ra_full[RW-1:avru_pkg::TRIG_FRAC];
      rb_r <= rb_full[RW-1:avru_pkg::TRIG_FRAC];
      sn_r <= ss_r;
    end
  end

  always_comb begin
    a_sat   = sat_coord(ra_r);
    b_sat   = sat_coord(rb_r);
    bad_nxt = 1'b0;
    case (sn_r.axis)
      avru_pkg::AXIS_X: begin
        x_nxt = sn_r.pass;
        y_nxt = a_sat;
        z_nxt = b_sat;
      end
      avru_pkg::AXIS_Y: begin
        x_nxt = b_sat;
        y_nxt = sn_r.pass;
        z_nxt = a_sat;
      end
      avru_pkg::AXIS_Z: begin
        x_nxt = a_sat;
        y_nxt = b_sat;
        z_nxt = sn_r.pass;
      end
      default: begin
        x_nxt   = '0;
        y_nxt   = '0;
        z_nxt   = '0;
        bad_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      bad_r <= bad_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/axis_vector_rotation_unit.sv]
// Top level of the 3D vector rotation unit about a principal axis.
// Instantiates avru_angle, avru_cordic and avru_rotate; depends on avru_pkg.
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   in_tdata: x, y, z, angle_deg; in_tuser: axis_sel
//   out_     out  out_tvalid/out_tready out_tdata: x, y, z; out_tuser: bad_axis
//
// Throughput is one transaction per cycle while out_tready is held high. The stages are
// five for angle reduction and degree-to-radian scaling, one per CORDIC stage (16), and
// four for the products, sums, rounding and output register.
// Every stage carries its own valid bit and loads when empty or when the next
// stage moves, so bubbles collapse and input is taken while a result waits.
// Reset clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none

module axis_vector_rotation_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // in_x, in_y, in_z, angle_deg
  input  wire logic [1:0]   in_tuser,   // axis_sel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,  // out_x, out_y, out_z
  output logic [0:0]        out_tuser   // bad_axis
);

  localparam int CW = avru_pkg::COORD_W;

  logic signed [CW-1:0]               in_x, in_y, in_z;
  logic signed [avru_pkg::ANGLE_W-1:0] angle;
  avru_pkg::axis_t                    axis;
  avru_pkg::side_t                    side_in;

  logic                               ang_valid, ang_ready;
  logic signed [avru_pkg::TRIG_W-1:0] theta;
  avru_pkg::side_t                    ang_side;

  logic                               cor_valid, cor_ready;
  logic signed [avru_pkg::TRIG_W-1:0] cos_v, sin_v;
  avru_pkg::side_t                    cor_side;

  logic signed [CW-1:0]               rx, ry, rz;
  logic                               rbad;

  assign in_x  = in_tdata[CW-1:0];
  assign in_y  = in_tdata[2*CW-1:CW];
  assign in_z  = in_tdata[3*CW-1:2*CW];
  assign angle = in_tdata[127:96];
  assign axis  = avru_pkg::axis_t'(in_tuser);

  // pick the rotated pair (p, q) so that a = p*c - q*s and b = p*s + q*c
  always_comb begin
    side_in.axis = axis;
    side_in.neg  = 1'b0;
    case (axis)
      avru_pkg::AXIS_X: begin
        side_in.pass = in_x;
        side_in.p    = in_y;
        side_in.q    = in_z;
      end
      avru_pkg::AXIS_Y: begin
        side_in.pass = in_y;
        side_in.p    = in_z;
        side_in.q    = in_x;
      end
      avru_pkg::AXIS_Z: begin
        side_in.pass = in_z;
        side_in.p    = in_x;
        side_in.q    = in_y;
      end
      default: begin
        side_in.pass = '0;
        side_in.p    = '0;
        side_in.q    = '0;
      end
    endcase
  end

  avru_angle u_angle (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_tvalid),
    .ready_o (in_tready),
    .angle_i (angle),
    .side_i  (side_in),
    .valid_o (ang_valid),
    .ready_i (ang_ready),
    .theta_o (theta),
    .side_o  (ang_side)
  );

  avru_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (ang_valid),
    .ready_o (ang_ready),
    .theta_i (theta),
    .side_i  (ang_side),
    .valid_o (cor_valid),
    .ready_i (cor_ready),
    .cos_o   (cos_v),
    .sin_o   (sin_v),
    .side_o  (cor_side)
  );

  avru_rotate u_rotate (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (cor_valid),
    .ready_o (cor_ready),
    .cos_i   (cos_v),
    .sin_i   (sin_v),
    .side_i  (cor_side),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .x_o     (rx),
    .y_o     (ry),
    .z_o     (rz),
    .bad_o   (rbad)
  );

  assign out_tdata = {rz, ry, rx};
  assign out_tuser = rbad;

`ifndef SYNTHESIS
  a_bad_axis_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("bad axis result carries nonzero coordinates");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("pipeline refuses input while output register is empty");

  a_drain_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("pipeline stalls input while output is being taken");
`endif

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for axis_vector_rotation_unit: rotates random and corner-case vectors
// and compares every output transaction with a bit-exact fixed-point CORDIC predictor.
// Depends on avru_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb;

  localparam int     CLK_PERIOD      = 12;
  localparam int     ONE_Q16         = 65536;
  localparam int     ITEMS_PER_PHASE = 250;
  localparam int     PRESSURE_ITEMS  = 150;
  localparam int     TAIL_ITEMS      = 100;
  localparam int     HOLD_OFF_CYCLES = 120;
  localparam int     SETTLE_CYCLES   = 40;
  localparam int     CYCLE_LIMIT     = 400000;
  localparam int     SEND_IDLE [4]   = '{0, 86, 0, 28};
  localparam int     RECV_STALL [4]  = '{0, 0, 86, 28};

  localparam longint FULL_TURN       = 360 * 65536;
  localparam longint HALF_TURN       = 180 * 65536;
  localparam longint QUARTER_TURN    = 90 * 65536;
  localparam longint RAD_PER_DEG_Q44 = 64'sd307041569098;
  localparam longint GAIN_Q30        = 64'sd652032874;
  localparam longint ATAN_Q30 [32]   = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0
  };

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        bad;
  } rotated_t;

  class rotation_scoreboard;
    rotated_t    expected_q[$];
    int unsigned errors;
    int unsigned bad_axis_count;
    int unsigned full_scale_count;
    int unsigned axis_count [3];

    static function logic [31:0] clamp_coord(longint v);
      if (v > 64'sd2147483647) begin
        return 32'h7fff_ffff;
      end
      if (v < -64'sd2147483648) begin
        return 32'h8000_0000;
      end
      return v[31:0];
    endfunction

    // round((a*c + b*s) / 2^30) to nearest, computed wide
    static function longint dot_round(longint a, longint c, longint b, longint s);
      logic signed [127:0] wa, wc, wb, ws, acc;
      wa = a;
      wc = c;
      wb = b;
      ws = s;
      acc = wa * wc + wb * ws + (128'sd1 <<< 29);
      return longint'(acc >>> 30);
    endfunction

    function rotated_t rotate_vector(logic [127:0] data, logic [1:0] sel);
      longint   px, py, pz, a, theta, cx, sy, tx, ty, cs, sn;
      logic     flip;
      rotated_t r;
      px = longint'($signed(data[31:0]));
      py = longint'($signed(data[63:32]));
      pz = longint'($signed(data[95:64]));
      a = longint'($signed(data[127:96])) % FULL_TURN;
      if (a < 0) begin
        a += FULL_TURN;
      end
      if (a >= HALF_TURN) begin
        a -= FULL_TURN;
      end
      flip = 1'b0;
      if (a > QUARTER_TURN) begin
        a -= HALF_TURN;
        flip = 1'b1;
      end else if (a < -QUARTER_TURN) begin
        a += HALF_TURN;
        flip = 1'b1;
      end
      theta = (a * RAD_PER_DEG_Q44 + (64'sd1 <<< 29)) >>> 30;
      cx = GAIN_Q30;
      sy = 0;
      for (int i = 0; i < avru_pkg::CORDIC_STAGES && i < 32; i++) begin
        tx = sy >>> i;
        ty = cx >>> i;
        if (theta >= 0) begin
          cx -= tx;
          sy += ty;
          theta -= ATAN_Q30[i];
        end else begin
          cx += tx;
          sy -= ty;
          theta += ATAN_Q30[i];
        end
      end
      cs = flip ? -cx : cx;
      sn = flip ? -sy : sy;
      r.bad = 1'b0;
      case (avru_pkg::axis_t'(sel))
        avru_pkg::AXIS_X: begin
          r.x = clamp_coord(px);
          r.y = clamp_coord(dot_round(py, cs, pz, -sn));
          r.z = clamp_coord(dot_round(py, sn, pz, cs));
        end
        avru_pkg::AXIS_Y: begin
          r.x = clamp_coord(dot_round(px, cs, pz, sn));
          r.y = clamp_coord(py);
          r.z = clamp_coord(dot_round(pz, cs, px, -sn));
        end
        avru_pkg::AXIS_Z: begin
          r.x = clamp_coord(dot_round(px, cs, py, -sn));
          r.y = clamp_coord(dot_round(px, sn, py, cs));
          r.z = clamp_coord(pz);
        end
        default: begin
          r.x = '0;
          r.y = '0;
          r.z = '0;
          r.bad = 1'b1;
        end
      endcase
      return r;
    endfunction

    function void note_vector(logic [127:0] data, logic [1:0] sel);
      rotated_t r;
      r = rotate_vector(data, sel);
      expected_q.push_back(r);
      if (r.bad) begin
        bad_axis_count++;
      end else begin
        axis_count[sel]++;
      end
      if (r.x inside {32'h7fff_ffff, 32'h8000_0000} || r.y inside {32'h7fff_ffff, 32'h8000_0000}
          || r.z inside {32'h7fff_ffff, 32'h8000_0000}) begin
        full_scale_count++;
      end
    endfunction

    function void compare_coord(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
        errors++;
      end
    endfunction

    function void check_rotated(logic [95:0] data, logic bad);
      rotated_t exp_r;
      if (expected_q.size() == 0) begin
        $error("output transaction with no vector pending: tdata %h tuser %b", data, bad);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_coord("out_x", exp_r.x, data[31:0]);
      compare_coord("out_y", exp_r.y, data[63:32]);
      compare_coord("out_z", exp_r.z, data[95:64]);
      if (exp_r.bad !== bad) begin
        $error("bad_axis mismatch: expected %0d, actual %0d", exp_r.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // in_x, in_y, in_z, angle_deg
  logic [1:0]   in_tuser;   // axis_sel
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;  // out_x, out_y, out_z
  logic [0:0]   out_tuser;  // bad_axis

  rotation_scoreboard sb = new();
  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;
  logic               hold_req;
  int                 hold_left;
  int                 cycle_count;

  axis_vector_rotation_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hold off the output for a long stretch on request, else stall at random
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_vector(in_tdata, in_tuser);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_rotated(out_tdata, out_tuser[0]);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_vector(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                             input logic [1:0] sel, input logic [31:0] ang);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ang, z, y, x};
    in_tuser  <= sel;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [31:0] c [3];
    logic [31:0] ang;
    logic [1:0]  sel;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(3))
        0: c[k] = $urandom;
        1: c[k] = 32'($urandom_range(2097152)) - 32'd1048576;
        2: begin
          case ($urandom_range(4))
            0: c[k] = 32'h7fff_ffff;
            1: c[k] = 32'h8000_0000;
            2: c[k] = 32'h0;
            3: c[k] = 32'hffff_ffff;
            default: c[k] = 32'(ONE_Q16);
          endcase
        end
        default: c[k] = 32'($signed($urandom) >>> 4);
      endcase
    end
    case ($urandom_range(3))
      0: ang = $urandom;
      1: ang = 32'($urandom_range(47185920)) - 32'd23592960;
      2: ang = 32'((int'($urandom_range(8)) - 4) * 90 * ONE_Q16 + int'($urandom_range(4)) - 2);
      default: ang = 32'((int'($urandom_range(4000)) - 2000) * ONE_Q16);
    endcase
    sel = ($urandom_range(11) == 0) ? avru_pkg::AXIS_BAD : 2'($urandom_range(2));
    send_vector(c[0], c[1], c[2], sel, ang);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    hold_req       = 1'b0;
    hold_left      = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_vector(32'h0, 32'h0, 32'h0, avru_pkg::AXIS_X, 32'h0);
    send_vector(32'(ONE_Q16), 32'(2 * ONE_Q16), 32'(3 * ONE_Q16), avru_pkg::AXIS_X,
                32'(90 * ONE_Q16));
    send_vector(32'(ONE_Q16), 32'(2 * ONE_Q16), 32'(3 * ONE_Q16), avru_pkg::AXIS_Y,
                32'(90 * ONE_Q16));
    send_vector(32'(ONE_Q16), 32'(2 * ONE_Q16), 32'(3 * ONE_Q16), avru_pkg::AXIS_Z,
                32'(90 * ONE_Q16));
    send_vector(32'(ONE_Q16), 32'(2 * ONE_Q16), 32'(3 * ONE_Q16), avru_pkg::AXIS_Z,
                32'(180 * ONE_Q16));
    send_vector(32'(ONE_Q16), 32'(2 * ONE_Q16), 32'(3 * ONE_Q16), avru_pkg::AXIS_Z,
                32'(270 * ONE_Q16));
    send_vector(32'(ONE_Q16), 32'(2 * ONE_Q16), 32'(3 * ONE_Q16), avru_pkg::AXIS_Z,
                32'(-90 * ONE_Q16));
    send_vector(32'(ONE_Q16), 32'(2 * ONE_Q16), 32'(3 * ONE_Q16), avru_pkg::AXIS_Z,
                32'(360 * ONE_Q16));
    send_vector(32'(ONE_Q16), 32'(2 * ONE_Q16), 32'(3 * ONE_Q16), avru_pkg::AXIS_Z,
                32'(-180 * ONE_Q16));
    send_vector(32'(-5 * ONE_Q16), 32'(7 * ONE_Q16), 32'(ONE_Q16), avru_pkg::AXIS_Y,
                32'(90 * ONE_Q16 + 1));
    send_vector(32'(-5 * ONE_Q16), 32'(7 * ONE_Q16), 32'(ONE_Q16), avru_pkg::AXIS_X,
                32'(-90 * ONE_Q16 - 1));
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, avru_pkg::AXIS_X,
                32'h7fff_ffff);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, avru_pkg::AXIS_Y,
                32'h8000_0000);
    send_vector(32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, avru_pkg::AXIS_BAD,
                32'(30 * ONE_Q16));
    send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, avru_pkg::AXIS_BAD,
                32'hffff_ffff);
    // drive rotated coordinates past full scale in both directions
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, avru_pkg::AXIS_Z, 32'(45 * ONE_Q16));
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h0, avru_pkg::AXIS_Z, 32'(45 * ONE_Q16));
    send_vector(32'h0, 32'h7fff_ffff, 32'h7fff_ffff, avru_pkg::AXIS_X, 32'(45 * ONE_Q16));
    send_vector(32'h7fff_ffff, 32'h0, 32'h8000_0000, avru_pkg::AXIS_Y, 32'(-45 * ONE_Q16));
    send_vector(32'(3 * ONE_Q16), 32'(-4 * ONE_Q16), 32'(ONE_Q16), avru_pkg::AXIS_Z,
                32'(750 * ONE_Q16));
    send_vector(32'(3 * ONE_Q16), 32'(-4 * ONE_Q16), 32'(ONE_Q16), avru_pkg::AXIS_X,
                32'(-1000 * ONE_Q16));
    send_vector(32'(3 * ONE_Q16), 32'(-4 * ONE_Q16), 32'(ONE_Q16), avru_pkg::AXIS_Y, 32'h1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      repeat (ITEMS_PER_PHASE) send_random();
      drain();
    end

    // keep offering input while the output is held off, so the pipeline backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    repeat (PRESSURE_ITEMS) send_random();
    drain();

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    repeat (TAIL_ITEMS) send_random();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d rotations about x/y/z (%0d/%0d/%0d), %0d invalid-axis vectors, %0d %s",
             sb.axis_count[0] + sb.axis_count[1] + sb.axis_count[2], sb.axis_count[0],
             sb.axis_count[1], sb.axis_count[2], sb.bad_axis_count, sb.full_scale_count,
             "results at full scale");
    $display("flow control: free-running, 86%% input gaps, 86%% output stalls, 28%% both, %0d%s",
             HOLD_OFF_CYCLES, "-cycle output hold-off");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/avru_pkg.sv
rtl/core/avru_angle.sv
rtl/core/avru_cordic.sv
rtl/core/avru_rotate.sv
rtl/core/axis_vector_rotation_unit.sv
verif/tb.sv
